FILE: sv/dteq_pkg.sv
// ----------------------------------------------------------------------------
// dteq_pkg
// Shared types, result codes and helpers for the delayed timer event queue.
// ----------------------------------------------------------------------------
`default_nettype none

package dteq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_W      = 48;
  localparam int SEQ_W       = 32;
  localparam int TAG_W       = 8;
  localparam int ARG_W       = 32;

  localparam logic [1:0] FUNC_SCHED  = 2'd0;
  localparam logic [1:0] FUNC_TICK   = 2'd1;
  localparam logic [1:0] FUNC_CANCEL = 2'd2;

  localparam logic [2:0] KIND_ACCEPT  = 3'd0;
  localparam logic [2:0] KIND_REJECT  = 3'd1;
  localparam logic [2:0] KIND_STARTED = 3'd2;
  localparam logic [2:0] KIND_EVENT   = 3'd3;
  localparam logic [2:0] KIND_DONE    = 3'd4;

  typedef struct packed {
    logic        [1:0]  func;
    logic signed [31:0] delay;
    logic        [31:0] delta;
    logic        [7:0]  tag;
  } in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] event_tag;
    logic       last;
  } out_t;

  typedef enum logic [1:0] {
    OP_SCHED  = 2'd0,
    OP_TICK   = 2'd1,
    OP_CANCEL = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [ARG_W-1:0]  arg;
    logic [TAG_W-1:0]  tag;
  } cmd_t;

  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [ARG_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W + 1 - ARG_W){1'b0}}, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/dteq_front.sv
// ----------------------------------------------------------------------------
// dteq_front
// Input stage: accepts transactions, decodes the operation, clamps the delay.
// ----------------------------------------------------------------------------
`default_nettype none

module dteq_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dteq_pkg::in_t  in_data,
  output logic                cmd_valid,
  input  wire logic           cmd_ready,
  output dteq_pkg::cmd_t      cmd_data
);

  logic            fv_r;
  dteq_pkg::cmd_t  cmd_r;
  dteq_pkg::cmd_t  cmd_nxt;
  logic            keep;

  assign in_ready  = !fv_r || cmd_ready;
  assign cmd_valid = fv_r;
  assign cmd_data  = cmd_r;

  always_comb begin
    cmd_nxt.tag = in_data.tag;
    cmd_nxt.arg = in_data.delta;
    cmd_nxt.op  = dteq_pkg::OP_TICK;
    keep        = 1'b1;
    unique case (in_data.func)
      dteq_pkg::FUNC_SCHED: begin
        cmd_nxt.op  = dteq_pkg::OP_SCHED;
        cmd_nxt.arg = in_data.delay[31] ? '0 : in_data.delay;
      end
      dteq_pkg::FUNC_TICK: begin
        cmd_nxt.op = dteq_pkg::OP_TICK;
      end
      dteq_pkg::FUNC_CANCEL: begin
        cmd_nxt.op = dteq_pkg::OP_CANCEL;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_ready) begin
      fv_r <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dteq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// dteq_cmd_fifo
// Two-entry command queue between the input stage and the timer engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dteq_cmd_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire dteq_pkg::cmd_t wr_data,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output dteq_pkg::cmd_t      rd_data
);

  dteq_pkg::cmd_t mem [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           push;
  logic           pop;

  assign wr_ready = count_r != 2'd2;
  assign rd_valid = count_r != 2'd0;
  assign rd_data  = mem[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dteq_back.sv
// ----------------------------------------------------------------------------
// dteq_back
// Timer engine: slot store, start delay, elapsed time, due-event scan.
// ----------------------------------------------------------------------------
`default_nettype none

module dteq_back #(
  parameter int QUEUE_DEPTH = dteq_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire dteq_pkg::cmd_t cmd_data,
  input  wire logic           cfg_valid,
  input  wire logic [31:0]    cfg_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dteq_pkg::out_t      out_data
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int TW    = dteq_pkg::TIME_W;
  localparam int SW    = dteq_pkg::SEQ_W;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADV  = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                  state_r;
  logic                    started_r;
  logic [31:0]             delay_left_r;
  logic [TW-1:0]           elapsed_r;
  logic [TW-1:0]           elapsed_nxt;
  logic [SW-1:0]           next_seq_r;
  logic [QUEUE_DEPTH-1:0]  valid_r;
  logic [TW-1:0]           due_mem [QUEUE_DEPTH];
  logic [7:0]              tag_mem [QUEUE_DEPTH];
  logic [SW-1:0]           seq_mem [QUEUE_DEPTH];
  logic [31:0]             delta_r;
  logic [IDX_W-1:0]        idx_r;
  logic                    found_r;
  logic [IDX_W-1:0]        best_idx_r;
  logic [TW-1:0]           best_due_r;
  logic [SW-1:0]           best_age_r;
  logic [7:0]              best_tag_r;
  logic                    out_valid_r;
  dteq_pkg::out_t          out_r;

  logic                    out_free;
  logic                    out_load;
  logic                    pop;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;
  logic                    sched_wr;
  logic [TW-1:0]           cur_due;
  logic [SW-1:0]           cur_age;
  logic                    cand;
  logic                    last_idx;

  assign out_free  = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE) && out_free;
  assign pop       = cmd_valid && cmd_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign sched_wr  = pop && (cmd_data.op == dteq_pkg::OP_SCHED) && free_found;
  assign out_load  = (pop && ((cmd_data.op == dteq_pkg::OP_SCHED) ||
                              ((cmd_data.op == dteq_pkg::OP_TICK) && !started_r))) ||
                     ((state_r == S_EMIT) && out_free);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (!free_found && !valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  assign cur_due     = due_mem[idx_r];
  assign cur_age     = next_seq_r - seq_mem[idx_r];
  assign cand        = valid_r[idx_r] && (cur_due <= elapsed_r) &&
                       (!found_r || (cur_due < best_due_r) ||
                        ((cur_due == best_due_r) && (cur_age > best_age_r)));
  assign last_idx    = idx_r == IDX_W'(QUEUE_DEPTH - 1);
  assign elapsed_nxt = dteq_pkg::sat_add(elapsed_r, delta_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      started_r    <= 1'b0;
      delay_left_r <= '0;
      elapsed_r    <= '0;
      next_seq_r   <= '0;
      valid_r      <= '0;
      idx_r        <= '0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !out_load) out_valid_r <= 1'b0;
      if (cfg_valid && !started_r) delay_left_r <= cfg_data;
      unique case (state_r)
        S_IDLE: begin
          if (pop) begin
            unique case (cmd_data.op)
              dteq_pkg::OP_SCHED: begin
                out_valid_r <= 1'b1;
                if (free_found) begin
                  valid_r[free_idx] <= 1'b1;
                  next_seq_r        <= next_seq_r + 1'b1;
                end
              end
              dteq_pkg::OP_TICK: begin
                if (!started_r && (delay_left_r > cmd_data.arg)) begin
                  delay_left_r <= delay_left_r - cmd_data.arg;
                  out_valid_r  <= 1'b1;
                end else begin
                  state_r <= S_ADV;
                  if (!started_r) begin
                    delay_left_r <= '0;
                    started_r    <= 1'b1;
                    out_valid_r  <= 1'b1;
                  end
                end
              end
              dteq_pkg::OP_CANCEL: begin
                valid_r <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_ADV: begin
          elapsed_r <= elapsed_nxt;
          idx_r     <= '0;
          found_r   <= 1'b0;
          state_r   <= S_SCAN;
        end
        S_SCAN: begin
          if (cand) found_r <= 1'b1;
          if (last_idx) begin
            state_r <= S_EMIT;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (found_r) begin
              valid_r[best_idx_r] <= 1'b0;
              idx_r               <= '0;
              found_r             <= 1'b0;
              state_r             <= S_SCAN;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sched_wr) begin
      due_mem[free_idx] <= dteq_pkg::sat_add(elapsed_r, cmd_data.arg);
      tag_mem[free_idx] <= cmd_data.tag;
      seq_mem[free_idx] <= next_seq_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && pop && cmd_data.op == dteq_pkg::OP_TICK) begin
      delta_r <= started_r ? cmd_data.arg : cmd_data.arg - delay_left_r;
    end
    if (state_r == S_SCAN && cand) begin
      best_idx_r <= idx_r;
      best_due_r <= cur_due;
      best_age_r <= cur_age;
      best_tag_r <= tag_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && pop) begin
      out_r.event_tag <= '0;
      if (cmd_data.op == dteq_pkg::OP_SCHED) begin
        out_r.kind <= free_found ? dteq_pkg::KIND_ACCEPT : dteq_pkg::KIND_REJECT;
        out_r.last <= 1'b1;
      end else if (!started_r && (delay_left_r > cmd_data.arg)) begin
        out_r.kind <= dteq_pkg::KIND_DONE;
        out_r.last <= 1'b1;
      end else begin
        out_r.kind <= dteq_pkg::KIND_STARTED;
        out_r.last <= 1'b0;
      end
    end else if (state_r == S_EMIT && out_free) begin
      if (found_r) begin
        out_r.kind      <= dteq_pkg::KIND_EVENT;
        out_r.event_tag <= best_tag_r;
        out_r.last      <= 1'b0;
      end else begin
        out_r.kind      <= dteq_pkg::KIND_DONE;
        out_r.event_tag <= '0;
        out_r.last      <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/delayed_timer_event_queue.sv
// Schedule: one transaction per cycle while idle and its results are taken; cancel: none.
// Tick: elapsed time advances, then all slots are scanned once per due event and once more,
// giving each due event in turn, then the done result; the engine is busy through the tick.
// A tick still inside the start delay gives only its done result.
// A two-entry command queue lets input transactions land while a tick is running.
// Synchronous active-low reset empties the queue, clears time and start delay at once.
// ----------------------------------------------------------------------------
// delayed_timer_event_queue
// Timer event queue with a start delay and earliest-first due-event release.
// ----------------------------------------------------------------------------
`default_nettype none

module delayed_timer_event_queue #(
  parameter int QUEUE_DEPTH = dteq_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire dteq_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output dteq_pkg::out_t      out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [31:0]    cfg_data
);

  logic           f_valid;
  logic           f_ready;
  dteq_pkg::cmd_t f_data;
  logic           b_valid;
  logic           b_ready;
  dteq_pkg::cmd_t b_data;

  assign cfg_ready = 1'b1;

  dteq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd_data  (f_data)
  );

  dteq_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_data),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_data)
  );

  dteq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .cmd_data  (b_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

FILE: sv/dteq_checker.sv
// ----------------------------------------------------------------------------
// dteq_checker
// Port-level checks on the result stream of the timer event queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dteq_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire dteq_pkg::out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.kind <= dteq_pkg::KIND_DONE)
    else $error("unknown result kind");

  a_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != dteq_pkg::KIND_EVENT |-> out_data.event_tag == 8'd0)
    else $error("tag set on non-event result");

  a_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == dteq_pkg::KIND_ACCEPT ||
                  out_data.kind == dteq_pkg::KIND_REJECT ||
                  out_data.kind == dteq_pkg::KIND_DONE) |-> out_data.last)
    else $error("closing result without last");

  a_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == dteq_pkg::KIND_STARTED ||
                  out_data.kind == dteq_pkg::KIND_EVENT) |-> !out_data.last)
    else $error("last set mid-tick");

endmodule

bind delayed_timer_event_queue dteq_checker u_dteq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
